>>> rtl/cmts_pkg.sv
// ----------------------------------------------------------------------------
// cmts_pkg
// shared types and constants of the cube map texel sampler
// ----------------------------------------------------------------------------
package cmts_pkg;

    localparam int SIZE_W     = 7;               // face width / height register
    localparam int CHAN_W     = 3;               // channel count register
    localparam int DIR_W      = 16;              // direction component
    localparam int FACE_W     = 3;
    localparam int WADDR_W    = 14;
    localparam int NUM_FACES  = 6;
    localparam int NUM_BANKS  = 4;
    localparam int S_W        = DIR_W + 1;       // projected numerator and denominator
    localparam int NUM_W      = S_W + SIZE_W;    // numerator after scaling by size
    localparam int DIV_LAT    = SIZE_W + 1;      // multiply stage plus one stage per bit
    localparam int ROW_W      = 2 * SIZE_W;      // texel index within a face
    localparam int PROD_W     = ROW_W + CHAN_W;  // byte index before clamp
    localparam int QDEPTH     = 16;              // result queue entries
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // operations
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    typedef struct packed {
        logic                     op;
        logic [FACE_W-1:0]        write_face;
        logic [WADDR_W-1:0]       write_addr;
        logic [7:0]               write_byte;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [DIR_W-1:0]  dir_z;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic [FACE_W-1:0] face_hit;
        logic              bad_direction;
    } out_word_t;

endpackage

>>> rtl/cube_map_texel_sampler_core.sv
// ----------------------------------------------------------------------------
// cube_map_texel_sampler_core
// cube map texture store and direction sampler
// ----------------------------------------------------------------------------
// The block takes one word per clock while not stalled, a byte write or a
// direction sample, and returns one result word per sample through a 16-entry
// result queue. After it is accepted, a sample passes through face selection,
// the scaling multiply and the bit-per-stage divide of both face coordinates,
// the byte index multiply and clamp, bank address forming, the registered
// texture read and the queue write. Writes travel the same pipeline and reach
// the texture store at the same stage as sample reads, so every sample sees
// exactly the writes accepted before it. Input stall rises only when 16 samples
// are in flight or queued, so a waiting result does not hold up new words until
// the queue is full. The texture store is four byte-wide banks, which lets the
// four channel bytes of any byte index be read in the same cycle. Texture bytes
// are undefined until written; there is no clearing pass. Configuration is
// taken any cycle and must only change while the block is idle.
// ----------------------------------------------------------------------------
module cube_map_texel_sampler_core #(
    parameter int FACE_BYTES = 16384
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  cmts_pkg::in_word_t                    req,

    // result channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output cmts_pkg::out_word_t                   rsp,

    // configuration write port
    input  logic                                  cfg_we,
    input  logic [cmts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cmts_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int ROWS   = (FACE_BYTES + 3) / 4;              // rows per face per bank
    localparam int DEPTH  = cmts_pkg::NUM_FACES * ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDXW   = $clog2(FACE_BYTES);
    localparam int LIM    = FACE_BYTES - 4;
    localparam int CW     = (cmts_pkg::PROD_W > IDXW) ? cmts_pkg::PROD_W : IDXW;
    localparam int PEND_W = $clog2(cmts_pkg::QDEPTH + 1);
    localparam int SW     = cmts_pkg::S_W;
    localparam int LAT    = cmts_pkg::DIV_LAT;

    // item tag carried down the pipeline next to the arithmetic
    typedef struct packed {
        logic                           smp;
        logic                           wr;
        logic                           bad;
        logic [cmts_pkg::FACE_W-1:0]    face;
        logic [cmts_pkg::WADDR_W-1:0]   waddr;
        logic [7:0]                     wbyte;
    } tag_t;

    // configuration registers
    logic [cmts_pkg::SIZE_W-1:0] width_reg;
    logic [cmts_pkg::SIZE_W-1:0] height_reg;
    logic [cmts_pkg::CHAN_W-1:0] chan_reg;

    // handshake and credit
    logic              accept;
    logic              smp_acc;
    logic              pop;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    // face selection
    logic signed [SW:0]          xs, ys, zs;
    logic signed [SW:0]          ax, ay, az;
    logic signed [SW:0]          best;
    logic [cmts_pkg::FACE_W-1:0] face_sel;
    logic signed [SW:0]          m, ku, kv;
    logic signed [SW:0]          am, sum_u, sum_v, su, sv;
    tag_t                        tag_in;

    // stage 1
    logic [SW-1:0] s_u_reg, s_v_reg, den_reg;
    tag_t          tag_reg [LAT+1];

    // divider outputs
    logic [cmts_pkg::SIZE_W-1:0] q_u, q_v;
    logic [cmts_pkg::SIZE_W-1:0] cx, cy;

    // address stages
    logic [cmts_pkg::ROW_W-1:0]  row_reg;
    tag_t                        tag10_reg;
    logic [cmts_pkg::PROD_W-1:0] prod;
    logic [IDXW-1:0]             idx_reg;
    tag_t                        tag11_reg;
    logic [AW-1:0]               rd_addr_reg [cmts_pkg::NUM_BANKS];
    logic [1:0]                  lo_reg;
    logic                        wr_en_reg;
    logic [1:0]                  wr_bank_reg;
    logic [AW-1:0]               wr_addr_reg;
    logic [7:0]                  wr_data_reg;
    tag_t                        tag12_reg;
    logic                        wr_ok;

    // read stage
    logic [cmts_pkg::NUM_BANKS-1:0][7:0] rd_data;
    logic [1:0]                  lo13_reg;
    tag_t                        tag13_reg;
    cmts_pkg::out_word_t         res_word;
    logic                        fifo_valid;

    // texel coordinate clamp to [0, size - 1]; q exceeds size only when den is zero
    function automatic logic [cmts_pkg::SIZE_W-1:0] clamp_coord(
        input logic [cmts_pkg::SIZE_W-1:0] q,
        input logic [cmts_pkg::SIZE_W-1:0] size
    );
        logic [cmts_pkg::SIZE_W-1:0] r;
        if (size == '0)
        begin
            r = '0;
        end
        else if (q >= size)
        begin
            r = size - 1'b1;
        end
        else
        begin
            r = q;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd64;
            height_reg <= 7'd64;
            chan_reg   <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmts_pkg::CFG_FACE_WIDTH:    width_reg  <= cfg_data;
                cmts_pkg::CFG_FACE_HEIGHT:   height_reg <= cfg_data;
                cmts_pkg::CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[cmts_pkg::CHAN_W-1:0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input handshake: stall only when every queue slot is spoken for
    // ------------------------------------------------------------------
    assign req_stall = (pending_reg == PEND_W'(cmts_pkg::QDEPTH));
    assign accept    = req_valid && !req_stall;
    assign smp_acc   = accept && (req.op == cmts_pkg::OP_SAMPLE);
    assign pop       = rsp_valid && !rsp_stall;

    always_comb
    begin
        pending_next = pending_reg + PEND_W'(smp_acc) - PEND_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // face selection and projection
    // ------------------------------------------------------------------
    always_comb
    begin
        xs = (SW+1)'(req.dir_x);
        ys = (SW+1)'(req.dir_y);
        zs = (SW+1)'(req.dir_z);
        ax = xs[SW] ? -xs : xs;
        ay = ys[SW] ? -ys : ys;
        az = zs[SW] ? -zs : zs;

        // strict compares keep the earlier face on a tie
        best     = ax;
        face_sel = xs[SW] ? cmts_pkg::FACE_NX : cmts_pkg::FACE_PX;
        if (ay > best)
        begin
            best     = ay;
            face_sel = ys[SW] ? cmts_pkg::FACE_NY : cmts_pkg::FACE_PY;
        end
        if (az > best)
        begin
            best     = az;
            face_sel = zs[SW] ? cmts_pkg::FACE_NZ : cmts_pkg::FACE_PZ;
        end

        unique case (face_sel)
            cmts_pkg::FACE_PX: begin m = xs; ku = zs;  kv = ys;  end
            cmts_pkg::FACE_NX: begin m = xs; ku = zs;  kv = -ys; end
            cmts_pkg::FACE_PY: begin m = ys; ku = xs;  kv = zs;  end
            cmts_pkg::FACE_NY: begin m = ys; ku = -xs; kv = zs;  end
            cmts_pkg::FACE_PZ: begin m = zs; ku = -xs; kv = ys;  end
            default:           begin m = zs; ku = -xs; kv = -ys; end
        endcase

        // fold the sign of the major axis into numerator and denominator
        am    = m[SW] ? -m : m;
        sum_u = m + ku;
        sum_v = m + kv;
        su    = m[SW] ? -sum_u : sum_u;
        sv    = m[SW] ? -sum_v : sum_v;

        tag_in.smp   = smp_acc;
        tag_in.wr    = accept && (req.op == cmts_pkg::OP_WRITE);
        tag_in.bad   = (best == '0);
        tag_in.face  = (req.op == cmts_pkg::OP_WRITE) ? req.write_face : face_sel;
        tag_in.waddr = req.write_addr;
        tag_in.wbyte = req.write_byte;
    end

    always_ff @(posedge clk)
    begin
        s_u_reg <= su[SW-1:0];
        s_v_reg <= sv[SW-1:0];
        den_reg <= {am[SW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i <= LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // coordinate dividers
    // ------------------------------------------------------------------
    cmts_div u_div_u (
        .clk  (clk),
        .s    (s_u_reg),
        .den  (den_reg),
        .size (width_reg),
        .q    (q_u)
    );

    cmts_div u_div_v (
        .clk  (clk),
        .s    (s_v_reg),
        .den  (den_reg),
        .size (height_reg),
        .q    (q_v)
    );

    // ------------------------------------------------------------------
    // byte index
    // ------------------------------------------------------------------
    assign cx   = clamp_coord(q_u, width_reg);
    assign cy   = clamp_coord(q_v, height_reg);
    assign prod = cmts_pkg::PROD_W'(row_reg) * cmts_pkg::PROD_W'(chan_reg);

    always_ff @(posedge clk)
    begin
        row_reg <= cmts_pkg::ROW_W'(cy) * cmts_pkg::ROW_W'(width_reg)
                 + cmts_pkg::ROW_W'(cx);
        if (CW'(prod) > CW'(LIM))
        begin
            idx_reg <= IDXW'(LIM);
        end
        else
        begin
            idx_reg <= IDXW'(prod);
        end
    end

    // ------------------------------------------------------------------
    // bank addresses: channel j of index idx sits in bank (idx + j) mod 4
    // ------------------------------------------------------------------
    assign wr_ok = tag11_reg.wr
                && (tag11_reg.face < cmts_pkg::FACE_W'(cmts_pkg::NUM_FACES))
                && (32'(tag11_reg.waddr) < 32'(FACE_BYTES));

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < cmts_pkg::NUM_BANKS; b++)
        begin
            rd_addr_reg[b] <= AW'(tag11_reg.face) * AW'(ROWS)
                            + AW'((idx_reg + IDXW'(2'(2'(b) - idx_reg[1:0]))) >> 2);
        end
        lo_reg      <= idx_reg[1:0];
        wr_bank_reg <= tag11_reg.waddr[1:0];
        wr_addr_reg <= AW'(tag11_reg.face) * AW'(ROWS) + AW'(tag11_reg.waddr >> 2);
        wr_data_reg <= tag11_reg.wbyte;
        lo13_reg    <= lo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag10_reg <= '0;
            tag11_reg <= '0;
            tag12_reg <= '0;
            tag13_reg <= '0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            tag10_reg <= tag_reg[LAT];
            tag11_reg <= tag10_reg;
            tag12_reg <= tag11_reg;
            tag13_reg <= tag12_reg;
            wr_en_reg <= wr_ok;
        end
    end

    // ------------------------------------------------------------------
    // texture store
    // ------------------------------------------------------------------
    cmts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_addr (rd_addr_reg),
        .wr_en   (wr_en_reg),
        .wr_bank (wr_bank_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // result assembly, absent channels read as zero, a bad direction zeroes the word
    // ------------------------------------------------------------------
    always_comb
    begin
        res_word.red           = rd_data[lo13_reg];
        res_word.green         = (chan_reg > 3'd1) ? rd_data[lo13_reg + 2'd1] : 8'd0;
        res_word.blue          = (chan_reg > 3'd2) ? rd_data[lo13_reg + 2'd2] : 8'd0;
        res_word.alpha         = (chan_reg > 3'd3) ? rd_data[lo13_reg + 2'd3] : 8'd0;
        res_word.face_hit      = tag13_reg.face;
        res_word.bad_direction = 1'b0;
        if (tag13_reg.bad)
        begin
            res_word = '0;
            res_word.bad_direction = 1'b1;
        end
    end

    cmts_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tag13_reg.smp),
        .push_word (res_word),
        .pop       (pop),
        .word      (rsp),
        .valid     (fifo_valid)
    );

    assign rsp_valid = fifo_valid;

endmodule

>>> rtl/cmts_div.sv
// ----------------------------------------------------------------------------
// cmts_div
// pipelined restoring divider: q = floor(s * size / den), one bit per stage
// ----------------------------------------------------------------------------
module cmts_div (
    input  logic                         clk,
    input  logic [cmts_pkg::S_W-1:0]     s,
    input  logic [cmts_pkg::S_W-1:0]     den,
    input  logic [cmts_pkg::SIZE_W-1:0]  size,
    output logic [cmts_pkg::SIZE_W-1:0]  q
);

    localparam int QW = cmts_pkg::SIZE_W;
    localparam int NW = cmts_pkg::NUM_W;

    logic [NW-1:0]            rem_reg [QW+1];
    logic [cmts_pkg::S_W-1:0] den_reg [QW+1];
    logic [QW-1:0]            q_reg   [QW+1];
    logic [NW-1:0]            trial   [QW];

    // shifted divisor for each stage, msb of the quotient first
    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            trial[i] = NW'(den_reg[i]) << (QW - 1 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= NW'(s) * NW'(size);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        for (int i = 0; i < QW; i++)
        begin
            den_reg[i+1] <= den_reg[i];
            if (rem_reg[i] >= trial[i])
            begin
                rem_reg[i+1] <= rem_reg[i] - trial[i];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= rem_reg[i];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b0};
            end
        end
    end

    assign q = q_reg[QW];

endmodule

>>> rtl/cmts_mem.sv
// ----------------------------------------------------------------------------
// cmts_mem
// texture store: four byte-wide banks, one write and four reads per cycle
// ----------------------------------------------------------------------------
module cmts_mem #(
    parameter int DEPTH = 24576,
    parameter int AW    = 15
) (
    input  logic             clk,
    input  logic [AW-1:0]    rd_addr [cmts_pkg::NUM_BANKS],
    input  logic             wr_en,
    input  logic [1:0]       wr_bank,
    input  logic [AW-1:0]    wr_addr,
    input  logic [7:0]       wr_data,
    output logic [cmts_pkg::NUM_BANKS-1:0][7:0] rd_data
);

    for (genvar b = 0; b < cmts_pkg::NUM_BANKS; b++)
    begin : g_bank
        logic [7:0] ram [DEPTH];
        logic [7:0] rdata_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                ram[wr_addr] <= wr_data;
            end
            rdata_reg <= ram[rd_addr[b]];
        end

        assign rd_data[b] = rdata_reg;
    end

endmodule

>>> rtl/cmts_fifo.sv
// ----------------------------------------------------------------------------
// cmts_fifo
// result queue between the pipeline and the output channel
// ----------------------------------------------------------------------------
module cmts_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cmts_pkg::out_word_t push_word,
    input  logic                pop,
    output cmts_pkg::out_word_t word,
    output logic                valid
);

    localparam int PW = $clog2(cmts_pkg::QDEPTH);

    cmts_pkg::out_word_t ent_reg [cmts_pkg::QDEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         count_reg;
    logic [PW:0]         count_next;

    // room is guaranteed by the credit count at the input
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_comb
    begin
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign word  = ent_reg[rd_ptr_reg];

endmodule

>>> rtl/cmts_checker.sv
// ----------------------------------------------------------------------------
// cmts_checker
// port-level checks of the cube map texel sampler result channel
// ----------------------------------------------------------------------------
module cmts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input cmts_pkg::out_word_t rsp
);

    // a stalled word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    // a stalled word keeps its value
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result word changed while stalled");

    // zero direction gives an all-zero colour and face
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.bad_direction |->
            (rsp.red == 8'd0) && (rsp.green == 8'd0) && (rsp.blue == 8'd0)
            && (rsp.alpha == 8'd0) && (rsp.face_hit == cmts_pkg::FACE_PX))
        else $error("bad direction with nonzero result");

    // only the six real faces are reported
    a_face: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.face_hit <= cmts_pkg::FACE_NZ))
        else $error("face code out of range");

endmodule

bind cube_map_texel_sampler_core cmts_checker u_cmts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
